// File: design/bsr_pkg.sv
package bsr_pkg;

	// stack geometry
	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CAP_W = 5;
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// request codes
	typedef enum logic [2:0] {
		ACT_PUSH    = 3'd0,
		ACT_POP     = 3'd1,
		ACT_PEEK    = 3'd2,
		ACT_DUP     = 3'd3,
		ACT_ROT_UP  = 3'd4,
		ACT_ROT_DN  = 3'd5
	} bsr_action_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_IGNORED = 2'd3
	} bsr_status_t;

	// what every cell does in the cycle
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_WRITE,
		CELL_ROT_UP,
		CELL_ROT_DN
	} bsr_cell_op_t;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] push_value;
		logic [4:0] rotate_depth;
	} bsr_in_t;

	typedef struct packed {
		logic [7:0] read_value;
		logic [1:0] status;
	} bsr_out_t;

	// read side selects of a cell
	typedef struct packed {
		logic [CNT_W-1:0] fill;
		logic [CNT_W-1:0] lo;
	} bsr_tap_sel_t;

	// write side control broadcast to all cells
	typedef struct packed {
		bsr_cell_op_t     op;
		logic [CNT_W-1:0] fill;
		logic [CNT_W-1:0] lo;
		logic [7:0]       wdata;
	} bsr_wr_ctrl_t;

endpackage

// File: design/byte_stack_with_rotate.sv
// Byte LIFO stack with duplicate and rotate requests.
// Request channel: an item (action, push_value, rotate_depth) is taken at a
// rising edge with start high and busy low. busy stays low: every cycle can
// carry a new item.
// Result channel: done pulses for one cycle with read_value and status, in the
// cycle after the item was taken. Each item gives exactly one result.
// Throughput is one item per cycle: the row of entry cells shifts all
// entries of a rotation in the same cycle, and the fill count and result
// register close the loop for the next item. The receiver cannot stall;
// results must be taken as they appear. capacity is written by the user
// through capacity_we / capacity_wdata only while no item is in flight; the
// block does not enforce this. Values above the stack depth act as the depth.
// Reset clears the fill count, sets capacity to 16 and drops done.
// Entry contents are not cleared; only written entries are ever read.
module byte_stack_with_rotate (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  bsr_pkg::bsr_in_t               cmd,
	input  logic                           capacity_we,
	input  logic [bsr_pkg::CAP_W-1:0]      capacity_wdata,
	output logic                           done,
	output bsr_pkg::bsr_out_t              result
);
	import bsr_pkg::*;

	logic [CAP_W-1:0] capacity_q;
	logic [CNT_W-1:0] fill_q;
	logic             done_q;
	bsr_out_t         result_q;

	logic [7:0] cell_val [DEPTH];
	logic [7:0] top_tap  [DEPTH];
	logic [7:0] lo_tap   [DEPTH];

	logic             accept;
	logic [7:0]       top_val;
	logic [7:0]       lo_val;
	logic             empty;
	logic             full;
	logic             rot_ok;
	logic [CMP_W-1:0] eff_cap;
	logic [CNT_W-1:0] lo;
	bsr_tap_sel_t     tap_sel;
	bsr_wr_ctrl_t     wr_ctrl;
	logic [CNT_W-1:0] fill_d;
	bsr_out_t         result_d;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign done   = done_q;
	assign result = result_q;

	// fill and rotation window checks
	assign eff_cap = (CMP_W'(capacity_q) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(capacity_q);
	assign empty   = (fill_q == '0);
	assign full    = (CMP_W'(fill_q) >= eff_cap) || (CMP_W'(fill_q) >= CMP_W'(DEPTH));
	assign rot_ok  = (cmd.rotate_depth != '0) && (CMP_W'(cmd.rotate_depth) <= CMP_W'(fill_q));
	assign lo      = fill_q - CNT_W'(cmd.rotate_depth);

	assign tap_sel.fill = fill_q;
	assign tap_sel.lo   = lo;

	// gather the tapped entries from the row
	always_comb begin
		top_val = '0;
		lo_val  = '0;
		for (int i = 0; i < DEPTH; i++) begin
			top_val = top_val | top_tap[i];
			lo_val  = lo_val | lo_tap[i];
		end
	end

	// decode the item into cell control, next fill and the result
	always_comb begin
		wr_ctrl.op    = CELL_HOLD;
		wr_ctrl.fill  = fill_q;
		wr_ctrl.lo    = lo;
		wr_ctrl.wdata = cmd.push_value;
		fill_d        = fill_q;
		result_d.read_value = 8'd0;
		result_d.status     = ST_OK;
		unique case (cmd.action)
			ACT_PUSH: begin
				if (full) begin
					result_d.status = ST_FULL;
				end else begin
					wr_ctrl.op = CELL_WRITE;
					fill_d     = fill_q + CNT_W'(1);
				end
			end
			ACT_POP, ACT_PEEK: begin
				if (empty) begin
					result_d.status = ST_EMPTY;
				end else begin
					result_d.read_value = top_val;
					if (cmd.action == ACT_POP) begin
						fill_d = fill_q - CNT_W'(1);
					end
				end
			end
			ACT_DUP: begin
				if (empty) begin
					result_d.status = ST_EMPTY;
				end else if (full) begin
					result_d.status = ST_FULL;
				end else begin
					wr_ctrl.op    = CELL_WRITE;
					wr_ctrl.wdata = top_val;
					fill_d        = fill_q + CNT_W'(1);
				end
			end
			ACT_ROT_UP: begin
				if (rot_ok) begin
					wr_ctrl.op    = CELL_ROT_UP;
					wr_ctrl.wdata = top_val;
				end else begin
					result_d.status = ST_IGNORED;
				end
			end
			ACT_ROT_DN: begin
				if (rot_ok) begin
					wr_ctrl.op    = CELL_ROT_DN;
					wr_ctrl.wdata = lo_val;
				end else begin
					result_d.status = ST_IGNORED;
				end
			end
			default: begin
				result_d.status = ST_IGNORED;
			end
		endcase
		if (!accept) begin
			wr_ctrl.op = CELL_HOLD;
			fill_d     = fill_q;
		end
	end

	// row of entry cells, bottom of stack at cell 0
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [7:0] below;
		logic [7:0] above;
		if (g == 0) begin : g_bot
			assign below = 8'd0;
		end else begin : g_mid_lo
			assign below = cell_val[g-1];
		end
		if (g == DEPTH - 1) begin : g_top
			assign above = 8'd0;
		end else begin : g_mid_hi
			assign above = cell_val[g+1];
		end
		bsr_cell u_cell (
			.clk       (clk),
			.idx       (IDX_W'(g)),
			.sel       (tap_sel),
			.ctrl      (wr_ctrl),
			.below_val (below),
			.above_val (above),
			.val       (cell_val[g]),
			.top_tap   (top_tap[g]),
			.lo_tap    (lo_tap[g])
		);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
			fill_q     <= '0;
			done_q     <= 1'b0;
		end else begin
			if (capacity_we) begin
				capacity_q <= capacity_wdata;
			end
			fill_q <= fill_d;
			done_q <= accept;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result_d;
		end
	end

	// every taken item gives a result in the next cycle, and only then
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("item taken without a result strobe");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("result strobe without an item");

	// the fill count never runs past the row of cells
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(fill_q) <= CMP_W'(DEPTH))
		else $error("fill count beyond stack depth");

	// refused or ignored requests leave the fill count alone
	a_refused_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_OK) |-> $stable(fill_q))
		else $error("refused item changed the fill count");

endmodule

// File: design/bsr_cell.sv
module bsr_cell (
	input  logic                 clk,
	input  logic [bsr_pkg::IDX_W-1:0] idx,
	input  bsr_pkg::bsr_tap_sel_t sel,
	input  bsr_pkg::bsr_wr_ctrl_t ctrl,
	input  logic [7:0]           below_val,
	input  logic [7:0]           above_val,
	output logic [7:0]           val,
	output logic [7:0]           top_tap,
	output logic [7:0]           lo_tap
);
	import bsr_pkg::*;

	logic [7:0]       val_q;
	logic [CNT_W-1:0] pos;
	logic [CNT_W-1:0] pos_up;

	assign pos    = CNT_W'(idx);
	assign pos_up = pos + CNT_W'(1);
	assign val    = val_q;

	// taps for the top entry and the bottom of a rotation
	assign top_tap = (pos_up == sel.fill) ? val_q : 8'd0;
	assign lo_tap  = (pos == sel.lo) ? val_q : 8'd0;

	// entry update from the broadcast control and the neighbors
	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			CELL_WRITE: begin
				if (pos == ctrl.fill) begin
					val_q <= ctrl.wdata;
				end
			end
			CELL_ROT_UP: begin
				if (pos == ctrl.lo) begin
					val_q <= ctrl.wdata;
				end else if (pos > ctrl.lo && pos < ctrl.fill) begin
					val_q <= below_val;
				end
			end
			CELL_ROT_DN: begin
				if (pos_up == ctrl.fill) begin
					val_q <= ctrl.wdata;
				end else if (pos >= ctrl.lo && pos_up < ctrl.fill) begin
					val_q <= above_val;
				end
			end
			default: begin
				val_q <= val_q;
			end
		endcase
	end

endmodule

// File: tb/tb_byte_stack_with_rotate.sv
`timescale 1ns / 1ps

module tb_byte_stack_with_rotate;
	import bsr_pkg::*;

	// action codes the block does not use
	localparam logic [2:0] ACT_SPARE_6 = 3'd6;
	localparam logic [2:0] ACT_SPARE_7 = 3'd7;

	localparam int N_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 66;
	localparam int N_DIRECTED = 24;

	typedef struct {
		logic [2:0] action;
		logic [7:0] push_value;
		logic [4:0] rotate_depth;
		logic       typed;
		logic [7:0] read_value;
		logic [1:0] status;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	bsr_in_t cmd;
	logic capacity_we;
	logic [CAP_W-1:0] capacity_wdata;
	logic done;
	bsr_out_t result;

	// predictor state
	logic [7:0] stack_mem [DEPTH];
	int unsigned stack_fill;
	int unsigned stack_cap;

	bsr_out_t pending_results [$];
	int mismatch_count;

	// directed items, expected result typed in where it is obvious
	dir_row_t dir_rows [N_DIRECTED] = '{
		'{ACT_POP,     8'h00, 5'd0,  1'b1, 8'h00, ST_EMPTY},
		'{ACT_PEEK,    8'hFF, 5'd31, 1'b1, 8'h00, ST_EMPTY},
		'{ACT_DUP,     8'h00, 5'd0,  1'b1, 8'h00, ST_EMPTY},
		'{ACT_ROT_UP,  8'h00, 5'd1,  1'b1, 8'h00, ST_IGNORED},
		'{ACT_PUSH,    8'h00, 5'd0,  1'b1, 8'h00, ST_OK},
		'{ACT_PUSH,    8'hFF, 5'd31, 1'b1, 8'h00, ST_OK},
		'{ACT_PEEK,    8'h00, 5'd0,  1'b1, 8'hFF, ST_OK},
		'{ACT_DUP,     8'h00, 5'd0,  1'b1, 8'h00, ST_OK},
		'{ACT_PUSH,    8'hA5, 5'd0,  1'b0, 8'h00, ST_OK},
		'{ACT_PUSH,    8'h5A, 5'd0,  1'b0, 8'h00, ST_OK},
		'{ACT_PUSH,    8'h3C, 5'd0,  1'b0, 8'h00, ST_OK},
		'{ACT_ROT_UP,  8'h00, 5'd0,  1'b1, 8'h00, ST_IGNORED},
		'{ACT_ROT_DN,  8'h00, 5'd31, 1'b1, 8'h00, ST_IGNORED},
		'{ACT_ROT_UP,  8'h00, 5'd7,  1'b1, 8'h00, ST_IGNORED},
		'{ACT_ROT_UP,  8'h00, 5'd4,  1'b0, 8'h00, ST_OK},
		'{ACT_ROT_DN,  8'h00, 5'd6,  1'b0, 8'h00, ST_OK},
		'{ACT_ROT_DN,  8'h00, 5'd1,  1'b1, 8'h00, ST_OK},
		'{ACT_ROT_UP,  8'h00, 5'd6,  1'b0, 8'h00, ST_OK},
		'{ACT_SPARE_6, 8'h00, 5'd0,  1'b1, 8'h00, ST_IGNORED},
		'{ACT_SPARE_7, 8'hFF, 5'd31, 1'b1, 8'h00, ST_IGNORED},
		'{ACT_POP,     8'h00, 5'd0,  1'b0, 8'h00, ST_OK},
		'{ACT_POP,     8'h00, 5'd0,  1'b0, 8'h00, ST_OK},
		'{ACT_PEEK,    8'h00, 5'd0,  1'b0, 8'h00, ST_OK},
		'{ACT_ROT_DN,  8'h00, 5'd16, 1'b1, 8'h00, ST_IGNORED}
	};

	// capacity, sender idle percent and push percent of each random phase
	int unsigned phase_cap [N_PHASES] = '{16, 3, 0, 31, 1, 17, 9, 16};
	int unsigned phase_idle [N_PHASES] = '{0, 54, 35, 0, 54, 35, 0, 54};
	int unsigned phase_push [N_PHASES] = '{60, 50, 40, 75, 30, 55, 35, 50};

	byte_stack_with_rotate u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.cmd            (cmd),
		.capacity_we    (capacity_we),
		.capacity_wdata (capacity_wdata),
		.done           (done),
		.result         (result)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

	// expected result of one request, updates the stack copy
	task automatic stack_predict(input bsr_in_t req, output bsr_out_t res);
		int unsigned lim;
		int unsigned n;
		int unsigned lo;
		int i;
		logic [7:0] t;
		res = '0;
		res.status = ST_OK;
		lim = (stack_cap > DEPTH) ? DEPTH : stack_cap;
		n = req.rotate_depth;
		case (req.action)
			ACT_PUSH: begin
				if (stack_fill >= lim) begin
					res.status = ST_FULL;
				end else begin
					stack_mem[stack_fill] = req.push_value;
					stack_fill++;
				end
			end
			ACT_POP, ACT_PEEK: begin
				if (stack_fill == 0) begin
					res.status = ST_EMPTY;
				end else begin
					res.read_value = stack_mem[stack_fill - 1];
					if (req.action == ACT_POP)
						stack_fill--;
				end
			end
			ACT_DUP: begin
				if (stack_fill == 0) begin
					res.status = ST_EMPTY;
				end else if (stack_fill >= lim) begin
					res.status = ST_FULL;
				end else begin
					stack_mem[stack_fill] = stack_mem[stack_fill - 1];
					stack_fill++;
				end
			end
			ACT_ROT_UP, ACT_ROT_DN: begin
				if (n == 0 || n > stack_fill) begin
					res.status = ST_IGNORED;
				end else begin
					lo = stack_fill - n;
					if (req.action == ACT_ROT_UP) begin
						t = stack_mem[stack_fill - 1];
						for (i = stack_fill - 1; i > lo; i--)
							stack_mem[i] = stack_mem[i - 1];
						stack_mem[lo] = t;
					end else begin
						t = stack_mem[lo];
						for (i = lo; i + 1 < stack_fill; i++)
							stack_mem[i] = stack_mem[i + 1];
						stack_mem[stack_fill - 1] = t;
					end
				end
			end
			default: begin
				res.status = ST_IGNORED;
			end
		endcase
	endtask

	// hand one item to the block and queue what it must answer
	task automatic send_item(input bsr_in_t req, input int unsigned idle_pct,
			input logic typed, input bsr_out_t typed_res);
		bsr_out_t pred;
		while ($urandom_range(0, 99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		cmd <= req;
		do @(posedge clk); while (busy !== 1'b0);
		stack_predict(req, pred);
		pending_results.push_back(typed ? typed_res : pred);
	endtask

	// capacity write, only with nothing in flight
	task automatic write_capacity(input int unsigned value);
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
		capacity_we <= 1'b1;
		capacity_wdata <= value[CAP_W-1:0];
		@(posedge clk);
		stack_cap = value[CAP_W-1:0];
		@(negedge clk);
		capacity_we <= 1'b0;
	endtask

	// random request, rotate depth mostly drawn from zero to one past the current fill
	function automatic bsr_in_t random_item(input int unsigned push_pct);
		bsr_in_t req;
		int unsigned r;
		req.push_value = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 9) == 0)
			req.rotate_depth = 5'($urandom_range(0, 31));
		else
			req.rotate_depth = 5'($urandom_range(0, stack_fill + 1));
		r = $urandom_range(0, 99);
		if (r < push_pct) begin
			req.action = ACT_PUSH;
		end else if (r >= 97) begin
			req.action = (r == 99) ? ACT_SPARE_7 : ACT_SPARE_6;
		end else begin
			case ($urandom_range(0, 4))
				0: req.action = ACT_POP;
				1: req.action = ACT_PEEK;
				2: req.action = ACT_DUP;
				3: req.action = ACT_ROT_UP;
				default: req.action = ACT_ROT_DN;
			endcase
		end
		return req;
	endfunction

	// result checker
	always @(posedge clk) begin
		bsr_out_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("result with no item outstanding: read_value %0h status %0d",
					result.read_value, result.status);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (result.read_value !== want.read_value) begin
					$error("read_value: expected %0h, got %0h", want.read_value,
						result.read_value);
					mismatch_count++;
				end
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					mismatch_count++;
				end
			end
		end
	end

	// stimulus
	initial begin
		bsr_in_t req;
		bsr_out_t typed_res;
		int p;
		int k;
		mismatch_count = 0;
		stack_fill = 0;
		stack_cap = CAP_RESET;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		capacity_we = 1'b0;
		capacity_wdata = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed items at reset capacity
		for (k = 0; k < N_DIRECTED; k++) begin
			req.action = dir_rows[k].action;
			req.push_value = dir_rows[k].push_value;
			req.rotate_depth = dir_rows[k].rotate_depth;
			typed_res.read_value = dir_rows[k].read_value;
			typed_res.status = dir_rows[k].status;
			send_item(req, 0, dir_rows[k].typed, typed_res);
		end

		// random phases, capacity changed between them
		for (p = 0; p < N_PHASES; p++) begin
			write_capacity(phase_cap[p]);
			for (k = 0; k < ITEMS_PER_PHASE; k++)
				send_item(random_item(phase_push[p]), phase_idle[p], 1'b0, '0);
		end
		@(negedge clk);
		start <= 1'b0;

		// drain
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
